FILE: rtl/exl_pkg.sv
// Package for the expression token lexer: result word type, push bundle,
// token kind codes, queue sizing and character class functions.
// Depends on nothing; every other rtl file imports it.
package exl_pkg;

	localparam int POS_BITS_DEF = 16;

	localparam int          RES_DEPTH = 4;
	localparam int          RES_PTR_W = $clog2(RES_DEPTH);
	localparam int          RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] FIELD_MAX = 16'hFFFF;

	localparam logic [7:0]  CH_ZERO  = 8'h30;
	localparam logic [7:0]  CH_NINE  = 8'h39;
	localparam logic [7:0]  CH_EQ    = 8'h3D;
	localparam logic [7:0]  CH_BANG  = 8'h21;
	localparam logic [7:0]  CH_LT    = 8'h3C;
	localparam logic [7:0]  CH_GT    = 8'h3E;
	localparam logic [7:0]  CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		KIND_PUNCT = 2'd0,
		KIND_NUM   = 2'd1,
		KIND_EOF   = 2'd2,
		KIND_ERR   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [30:0] value;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic [15:0] start;
		logic [15:0] len;
		logic        ovf;
		logic        last;
	} res_t;

	// Results of one item on their way into the result queue.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
		       (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	function automatic logic is_held_op(input logic [7:0] c);
		return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
	endfunction

endpackage

FILE: rtl/exl_core.sv
// Lexer state register and the single-pass next-state and token logic.
// Depends on exl_pkg.
module exl_core #(
	parameter int POS_BITS = exl_pkg::POS_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    char_code,
	input  logic          end_mark,
	output exl_pkg::push_t push
);
	import exl_pkg::*;

	localparam int SW = (POS_BITS > 16) ? POS_BITS : 16;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_NUM  = 2'd1,
		MODE_HELD = 2'd2,
		MODE_ERR  = 2'd3
	} mode_t;

	mode_t               mode_q, mode_d;
	logic [30:0]         acc_q, acc_d;
	logic                ovf_q, ovf_d;
	logic [POS_BITS-1:0] start_q, start_d;
	logic [POS_BITS-1:0] cnt_q, cnt_d;
	logic [7:0]          held_q, held_d;
	logic [POS_BITS-1:0] pos_q, pos_d;

	logic        have_a, have_b, run_idle;
	res_t        res_a, res_b;
	logic [34:0] acc_x10;

	function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
		logic [SW-1:0] ve;
		ve = SW'(v);
		return (ve > SW'(FIELD_MAX)) ? FIELD_MAX : ve[15:0];
	endfunction

	function automatic logic [POS_BITS-1:0] bump(input logic [POS_BITS-1:0] v);
		return (&v) ? v : v + POS_BITS'(1);
	endfunction

	function automatic res_t mk(input kind_t k, input logic [30:0] val,
	                            input logic [7:0] a, input logic [7:0] b,
	                            input logic [15:0] s, input logic [15:0] l,
	                            input logic o);
		res_t r;
		r.kind  = k;
		r.value = val;
		r.c1    = a;
		r.c2    = b;
		r.start = s;
		r.len   = l;
		r.ovf   = o;
		r.last  = 1'b0;
		return r;
	endfunction

	// acc * 10 + digit, as shifts; the digit is the low nibble of '0'..'9'
	assign acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 35'(char_code[3:0]);

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		start_d  = start_q;
		cnt_d    = cnt_q;
		held_d   = held_q;
		pos_d    = pos_q;
		have_a   = 1'b0;
		have_b   = 1'b0;
		run_idle = 1'b0;
		res_a    = '0;
		res_b    = '0;
		if (end_mark) begin
			// flush whatever is pending, then end of file, then back to reset
			if (mode_q == MODE_NUM) begin
				have_a = 1'b1;
				res_a  = mk(KIND_NUM, acc_q, 8'd0, 8'd0, sat16(start_q), sat16(cnt_q), ovf_q);
			end else if (mode_q == MODE_HELD) begin
				have_a = 1'b1;
				res_a  = mk(KIND_PUNCT, 31'd0, held_q, 8'd0, sat16(start_q), 16'd1, 1'b0);
			end
			have_b  = 1'b1;
			res_b   = mk(KIND_EOF, 31'd0, 8'd0, 8'd0, sat16(pos_q), 16'd0, 1'b0);
			mode_d  = MODE_IDLE;
			acc_d   = '0;
			ovf_d   = 1'b0;
			start_d = '0;
			cnt_d   = '0;
			held_d  = '0;
			pos_d   = '0;
		end else begin
			unique case (mode_q)
				MODE_NUM: begin
					if (is_digit(char_code)) begin
						if (acc_x10 > 35'(VALUE_MAX)) begin
							acc_d = VALUE_MAX;
							ovf_d = 1'b1;
						end else begin
							acc_d = acc_x10[30:0];
						end
						cnt_d = bump(cnt_q);
					end else begin
						have_a   = 1'b1;
						res_a    = mk(KIND_NUM, acc_q, 8'd0, 8'd0, sat16(start_q),
						              sat16(cnt_q), ovf_q);
						mode_d   = MODE_IDLE;
						run_idle = 1'b1;
					end
				end
				MODE_HELD: begin
					have_a = 1'b1;
					mode_d = MODE_IDLE;
					if (char_code == CH_EQ) begin
						res_a = mk(KIND_PUNCT, 31'd0, held_q, char_code, sat16(start_q),
						           16'd2, 1'b0);
					end else begin
						res_a    = mk(KIND_PUNCT, 31'd0, held_q, 8'd0, sat16(start_q),
						              16'd1, 1'b0);
						run_idle = 1'b1;
					end
				end
				MODE_ERR: begin
				end
				MODE_IDLE: begin
					run_idle = 1'b1;
				end
				default: begin
				end
			endcase
			if (run_idle) begin
				if (is_space(char_code)) begin
				end else if (is_digit(char_code)) begin
					mode_d  = MODE_NUM;
					acc_d   = 31'(char_code[3:0]);
					ovf_d   = 1'b0;
					start_d = pos_q;
					cnt_d   = POS_BITS'(1);
				end else if (is_held_op(char_code)) begin
					mode_d  = MODE_HELD;
					held_d  = char_code;
					start_d = pos_q;
				end else if (is_punct(char_code)) begin
					have_b = 1'b1;
					res_b  = mk(KIND_PUNCT, 31'd0, char_code, 8'd0, sat16(pos_q), 16'd1, 1'b0);
				end else begin
					have_b = 1'b1;
					res_b  = mk(KIND_ERR, 31'd0, char_code, 8'd0, sat16(pos_q), 16'd1, 1'b0);
					mode_d = MODE_ERR;
				end
			end
			pos_d = bump(pos_q);
		end
	end

	// pack up to two results in order; mark the last one
	always_comb begin
		push    = '0;
		push.r0 = res_a;
		push.r1 = res_b;
		if (have_a && have_b) begin
			push.n       = 2'd2;
			push.r1.last = 1'b1;
		end else if (have_a) begin
			push.n       = 2'd1;
			push.r0.last = 1'b1;
		end else if (have_b) begin
			push.n       = 2'd1;
			push.r0      = res_b;
			push.r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			start_q <= '0;
			cnt_q   <= '0;
			held_q  <= '0;
			pos_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			start_q <= start_d;
			cnt_q   <= cnt_d;
			held_q  <= held_d;
			pos_q   <= pos_d;
		end
	end

endmodule

FILE: rtl/exl_res_fifo.sv
// Result queue: takes up to two result words a cycle, gives one a cycle when popped.
// Depends on exl_pkg.
module exl_res_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push_en,
	input  exl_pkg::push_t                push,
	input  logic                          pop,
	output exl_pkg::res_t                 head,
	output logic                          not_empty,
	output logic [exl_pkg::RES_CNT_W-1:0] free
);
	import exl_pkg::*;

	res_t                 mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_CNT_W-1:0] count_q;
	logic [1:0]           n_in;

	assign n_in      = push_en ? push.n : 2'd0;
	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign free      = RES_CNT_W'(RES_DEPTH) - count_q;

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (n_in == 2'd2) begin
			mem_q[wr_ptr_q + RES_PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(n_in);
			rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop);
			count_q  <= count_q + RES_CNT_W'(n_in) - RES_CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/expression_token_lexer.sv
// Streaming lexer for integer arithmetic expressions, one character word in,
// token words out. Depends on exl_pkg, exl_core and exl_res_fifo.
//
// Each accepted input word (a character, or end_mark for end of text) lands in
// an input register and is lexed in one pass against the lexer state once the
// result queue has room for all its tokens, producing zero, one or two token
// words (last_of_run marks the final one of an input word). Tokens go into a
// four-word result queue that drives the output port, so input keeps flowing
// while a token waits to be taken. A new character is accepted every cycle while
// the queue has room; a character that raises two tokens (a flushed number or
// held operator plus a new token, or a flush plus end of file) is still one
// input word, and the queue then drains at one token per cycle, so sustained
// rate is set by the output port taking one word per cycle. Numbers saturate at
// 2^31-1 with overflow set; positions and lengths count in POS_BITS-wide
// registers that saturate, and are reported clipped to 16 bits. After an
// invalid character, characters are dropped until end_mark, which gives end of
// file and returns the lexer to its reset state.
module expression_token_lexer #(
	parameter int POS_BITS = exl_pkg::POS_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   char_code,
	input  logic         end_mark,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [1:0]   token_kind,
	output logic [30:0]  number_value,
	output logic [7:0]   first_char,
	output logic [7:0]   second_char,
	output logic [15:0]  start_pos,
	output logic [15:0]  token_len,
	output logic         overflow,
	output logic         last_of_run
);
	import exl_pkg::*;

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 end_s1;
	logic                 fire;
	push_t                push;
	res_t                 head;
	logic [RES_CNT_W-1:0] free;

	// lex the held word only when the queue has room for all its tokens
	assign fire     = valid_s1 && (free >= RES_CNT_W'(push.n));
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: hold while stalled, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			end_s1  <= end_mark;
		end
	end

	exl_core #(
		.POS_BITS(POS_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (char_s1),
		.end_mark  (end_s1),
		.push      (push)
	);

	exl_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (fire),
		.push      (push),
		.pop       (out_valid && out_ready),
		.head      (head),
		.not_empty (out_valid),
		.free      (free)
	);

	assign token_kind   = head.kind;
	assign number_value = head.value;
	assign first_char   = head.c1;
	assign second_char  = head.c2;
	assign start_pos    = head.start;
	assign token_len    = head.len;
	assign overflow     = head.ovf;
	assign last_of_run  = head.last;

endmodule

FILE: rtl/exl_checker.sv
// Port-level checks on the lexer's token stream, bound to the top level.
// Depends on exl_pkg and expression_token_lexer.
module exl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  token_kind,
	input logic [30:0] number_value,
	input logic [7:0]  first_char,
	input logic [7:0]  second_char,
	input logic [15:0] token_len,
	input logic        overflow,
	input logic        last_of_run
);
	import exl_pkg::*;

	// a stalled token word holds its kind, value, first character and length
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
		$stable(number_value) && $stable(first_char) && $stable(token_len))
		else $error("token word changed while stalled");

	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_EOF |-> last_of_run && token_len == 16'd0 &&
		number_value == 31'd0 && first_char == 8'd0 && !overflow)
		else $error("malformed end-of-file token");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_ERR |-> last_of_run && token_len == 16'd1 &&
		number_value == 31'd0 && second_char == 8'd0)
		else $error("malformed error token");

	a_num_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_NUM |-> token_len != 16'd0 &&
		first_char == 8'd0 && second_char == 8'd0)
		else $error("malformed number token");

endmodule

bind expression_token_lexer exl_checker u_exl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.token_kind   (token_kind),
	.number_value (number_value),
	.first_char   (first_char),
	.second_char  (second_char),
	.token_len    (token_len),
	.overflow     (overflow),
	.last_of_run  (last_of_run)
);

FILE: dv/expression_token_lexer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for expression_token_lexer: character words in, token words out.
// Depends on exl_pkg for the token kind codes, the result word layout and character constants.
module expression_token_lexer_tb;
	import exl_pkg::*;

	localparam int POS_W     = POS_BITS_DEF;
	localparam int RUN_ITEMS = 820;
	localparam int LONG_RUN  = 40;
	localparam logic [POS_W-1:0] POS_TOP = '1;

	// Lexer modes as the bench tracks them.
	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_NUMBER,
		SCAN_HELD,
		SCAN_DROP
	} scan_mode_t;

	// Track lexer state per accepted word and hold the token words it must produce.
	class token_scoreboard;
		res_t             awaited[$];
		res_t             run_toks[$];
		scan_mode_t       mode;
		logic [30:0]      acc;
		logic             acc_ovf;
		logic [POS_W-1:0] tok_start;
		logic [POS_W-1:0] digits;
		logic [POS_W-1:0] pos;
		logic [7:0]       held;
		int               words_noted;
		int               live_words;
		int               tokens_checked;
		int               bad_tokens;
		int               texts;

		function new();
			clear_state();
		endfunction

		function void clear_state();
			mode      = SCAN_IDLE;
			acc       = '0;
			acc_ovf   = 1'b0;
			tok_start = '0;
			digits    = '0;
			held      = '0;
			pos       = '0;
		endfunction

		function bit blank_char(logic [7:0] c);
			return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
		endfunction

		function bit decimal_char(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		function bit symbol_char(logic [7:0] c);
			return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			       (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
		endfunction

		function bit pair_lead(logic [7:0] c);
			return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT;
		endfunction

		function logic [POS_W-1:0] step_pos(logic [POS_W-1:0] v);
			return (v == POS_TOP) ? v : v + 1'b1;
		endfunction

		function logic [15:0] clip16(logic [POS_W-1:0] v);
			return (v > FIELD_MAX) ? FIELD_MAX : 16'(v);
		endfunction

		function void add_tok(kind_t k, logic [30:0] v, logic [7:0] c1, logic [7:0] c2,
		                      logic [POS_W-1:0] st, logic [POS_W-1:0] ln, logic ovf);
			res_t t;
			t.kind  = k;
			t.value = v;
			t.c1    = c1;
			t.c2    = c2;
			t.start = clip16(st);
			t.len   = clip16(ln);
			t.ovf   = ovf;
			t.last  = 1'b0;
			run_toks.push_back(t);
		endfunction

		function void flush_pending();
			if (mode == SCAN_NUMBER)
				add_tok(KIND_NUM, acc, 8'd0, 8'd0, tok_start, digits, acc_ovf);
			else if (mode == SCAN_HELD)
				add_tok(KIND_PUNCT, '0, held, 8'd0, tok_start, 'd1, 1'b0);
			mode = SCAN_IDLE;
		endfunction

		// Lex one character from the idle mode.
		function void take_fresh(logic [7:0] c);
			if (blank_char(c)) begin
				mode = SCAN_IDLE;
			end else if (decimal_char(c)) begin
				mode      = SCAN_NUMBER;
				acc       = 31'(c - CH_ZERO);
				acc_ovf   = 1'b0;
				tok_start = pos;
				digits    = 'd1;
			end else if (pair_lead(c)) begin
				mode      = SCAN_HELD;
				held      = c;
				tok_start = pos;
			end else if (symbol_char(c)) begin
				add_tok(KIND_PUNCT, '0, c, 8'd0, pos, 'd1, 1'b0);
			end else begin
				add_tok(KIND_ERR, '0, c, 8'd0, pos, 'd1, 1'b0);
				mode = SCAN_DROP;
			end
		endfunction

		function void note_word(logic [7:0] c, logic e);
			logic [63:0] grown;
			run_toks.delete();
			words_noted++;
			if (e || mode != SCAN_DROP)
				live_words++;
			if (e) begin
				flush_pending();
				add_tok(KIND_EOF, '0, 8'd0, 8'd0, pos, 'd0, 1'b0);
				clear_state();
				texts++;
			end else begin
				case (mode)
					SCAN_NUMBER: begin
						if (decimal_char(c)) begin
							grown = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
							if (grown > 64'(VALUE_MAX)) begin
								grown   = 64'(VALUE_MAX);
								acc_ovf = 1'b1;
							end
							acc    = grown[30:0];
							digits = step_pos(digits);
						end else begin
							flush_pending();
							take_fresh(c);
						end
					end
					SCAN_HELD: begin
						if (c == CH_EQ) begin
							add_tok(KIND_PUNCT, '0, held, c, tok_start, 'd2, 1'b0);
							mode = SCAN_IDLE;
						end else begin
							flush_pending();
							take_fresh(c);
						end
					end
					SCAN_DROP: begin
					end
					default: take_fresh(c);
				endcase
				pos = step_pos(pos);
			end
			if (run_toks.size() > 0)
				run_toks[run_toks.size() - 1].last = 1'b1;
			foreach (run_toks[i])
				awaited.push_back(run_toks[i]);
		endfunction

		function string show(res_t t);
			return $sformatf("kind=%0d value=%0d c1=%02h c2=%02h start=%0d len=%0d ovf=%0b last=%0b",
			                 t.kind, t.value, t.c1, t.c2, t.start, t.len, t.ovf, t.last);
		endfunction

		function void check_token(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				bad_tokens++;
				if (bad_tokens <= 10)
					$display("[%0t] unexpected token: %s", $realtime, show(got));
				return;
			end
			want = awaited.pop_front();
			tokens_checked++;
			if (got !== want) begin
				bad_tokens++;
				if (bad_tokens <= 10) begin
					$display("[%0t] token mismatch", $realtime);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = 8'd0;
	logic        end_mark  = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  token_kind;
	logic [30:0] number_value;
	logic [7:0]  first_char;
	logic [7:0]  second_char;
	logic [15:0] start_pos;
	logic [15:0] token_len;
	logic        overflow;
	logic        last_of_run;

	// Pacing knobs, in percent of cycles.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	token_scoreboard sb = new();

	expression_token_lexer #(
		.POS_BITS(POS_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.end_mark    (end_mark),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.number_value(number_value),
		.first_char  (first_char),
		.second_char (second_char),
		.start_pos   (start_pos),
		.token_len   (token_len),
		.overflow    (overflow),
		.last_of_run (last_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check each token word taken at this edge, then pick the ready level for the next one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_token(res_t'({token_kind, number_value, first_char, second_char,
			                       start_pos, token_len, overflow, last_of_run}));
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Offer one word, idling first at the sender rate, and hold it until taken.
	// Valid stays high after the accept; the next call or a drain decides its level.
	task automatic put_word(input logic [7:0] c, input logic e);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		end_mark  <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(c, e);
	endtask

	task automatic put_chars(input string s);
		foreach (s[i])
			put_word(s[i], 1'b0);
	endtask

	// Drop valid and wait until every predicted token word has come out.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_lead();
		case ($urandom_range(0, 3))
			0:       return CH_EQ;
			1:       return CH_BANG;
			2:       return CH_LT;
			default: return CH_GT;
		endcase
	endfunction

	// Build one text from random tokens: mostly well formed, a few stray bytes
	// that usually push the lexer into dropping characters until the end mark.
	task automatic random_text();
		int n_tok;
		int pick;
		int len;
		int r;
		n_tok = $urandom_range(1, 20);
		repeat (n_tok) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// Long runs now and then, so values saturate.
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 3);
				repeat (len)
					put_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
			end else if (pick < 50) begin
				put_word(pick_lead(), 1'b0);
				put_word(CH_EQ, 1'b0);
			end else if (pick < 60) begin
				put_word(pick_lead(), 1'b0);
			end else if (pick < 78) begin
				case ($urandom_range(0, 3))
					0:       put_word(8'($urandom_range(33, 47)), 1'b0);
					1:       put_word(8'($urandom_range(58, 64)), 1'b0);
					2:       put_word(8'($urandom_range(91, 96)), 1'b0);
					default: put_word(8'($urandom_range(123, 126)), 1'b0);
				endcase
			end else if (pick < 97) begin
				repeat ($urandom_range(1, 3)) begin
					r = $urandom_range(0, 6);
					put_word((r == 6) ? CH_SPACE : 8'(9 + r), 1'b0);
				end
			end else begin
				put_word(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		// The character field rides along with the end mark and must be ignored.
		put_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		int base;
		int leftover;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: white space, number flushed by a symbol, all four pairs, held
		// operators broken by a digit or white space, flush at the end mark, an
		// empty text, and errors on NUL and 0xFF with characters dropped after.
		put_chars("\t12+==!=<=>=<9>");
		put_word(8'd13, 1'b0);
		put_chars("!");
		put_word(8'd0, 1'b1);
		put_chars("5");
		put_word(8'hFF, 1'b1);
		put_word(8'd0, 1'b1);
		put_word(8'h00, 1'b0);
		put_chars("a");
		put_word(8'd0, 1'b1);
		put_word(8'hFF, 1'b0);
		put_word(8'hA5, 1'b1);
		hold_until_drained();

		// One longer text: the number overflows and keeps its saturated value,
		// then tokens and an error follow it.
		put_chars("1");
		repeat (LONG_RUN - 1)
			put_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
		put_chars("+<=*");
		put_word(8'h80, 1'b0);
		put_chars("A");
		put_word(8'd0, 1'b1);
		hold_until_drained();

		// Random texts under four pacing mixes.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 57;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 57;
				end
				default: begin
					send_idle_pct  = 11;
					recv_stall_pct = 11;
				end
			endcase
			base = sb.live_words;
			while (sb.live_words - base < RUN_ITEMS / 4)
				random_text();
			hold_until_drained();
		end

		// Give the pipe time to show any stray extra token.
		repeat (10) @(posedge clk);
		leftover = sb.awaited.size();
		if (leftover != 0)
			$display("%0d expected token words never arrived", leftover);
		$display("Lexed %0d words in %0d texts and checked %0d token words (%0d bad).",
		         sb.words_noted, sb.texts, sb.tokens_checked, sb.bad_tokens);
		$display("Covered pairs, held flushes, value overflow and errors under four pacing mixes.");
		if (sb.bad_tokens == 0 && leftover == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
